// ===== design/sufi_pkg.sv =====
`default_nettype none
package sufi_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_W         = 64;
    localparam int INDEX_W         = 10;
    localparam int COUNT_W         = 11;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_req;

    typedef struct packed {
        logic [INDEX_W-1:0]        first_index;
        logic                      is_new;
        logic signed [VALUE_W-1:0] unique_value;
        logic [COUNT_W-1:0]        unique_count;
        logic                      overflow;
        logic                      set_done;
    } t_out_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

endpackage
`default_nettype wire

// ===== design/stream_unique_first_index_top.sv =====
// Flow: an accepted request is compared against the N distinct values stored in the
//   current set and the result is registered once the scan ends; on a hit the scan
//   stops at the match. A stalled result holds the block for as long as it waits.
// Throughput: a request is taken only once the last result is issued; the scan reads
//   one table entry per cycle through the single read port of the key memory.
// Reset: synchronous, active low; clears control, count and mode. The key memory
//   needs no clearing pass, the fill count marks the valid entries.
`default_nettype none
module stream_unique_first_index_top #(
    parameter int TABLE_DEPTH = sufi_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sufi_pkg::t_in_req  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sufi_pkg::t_out_req      o_out_data
);
    import sufi_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_count, n_count;
    logic               r_rd_pend, n_rd_pend;
    logic [AW-1:0]      r_rd_addr, n_rd_addr;
    logic [VALUE_W-1:0] r_rd_data;
    logic               r_found, n_found;
    logic [AW-1:0]      r_hit_idx, n_hit_idx;
    logic [VALUE_W-1:0] r_key, n_key;
    logic               r_last, n_last;
    logic               r_wide;
    logic               r_out_valid, n_out_valid;
    t_out_req           r_out, n_out;

    logic               rd_en;
    logic               wr_en;
    logic               room;
    logic [AW+INDEX_W-1:0] idx_ext;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign room        = (r_count < CW'(TABLE_DEPTH));

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_rd_pend   = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_key       = r_key;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        idx_ext     = '0;
        cnt_ext     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key   = r_wide ? i_in_data.value
                                     : {{32{i_in_data.value[31]}}, i_in_data.value[31:0]};
                    n_last  = i_in_data.last;
                    n_ptr   = '0;
                    n_found = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_pend && (r_rd_data == r_key)) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_rd_addr;
                    n_state   = ST_RESP;
                end else if (r_ptr < r_count) begin
                    rd_en     = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_addr = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                end else if (!r_rd_pend) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.set_done        = r_last;
                    n_out.unique_value    = '0;
                    n_out.is_new          = 1'b0;
                    n_out.overflow        = 1'b0;
                    cnt_ext               = {{COUNT_W{1'b0}}, r_count};
                    priority if (r_found) begin
                        idx_ext = {{INDEX_W{1'b0}}, r_hit_idx};
                    end else if (room) begin
                        wr_en              = 1'b1;
                        idx_ext            = {{INDEX_W{1'b0}}, r_count[AW-1:0]};
                        cnt_ext            = {{COUNT_W{1'b0}}, r_count + CW'(1)};
                        n_count            = r_count + CW'(1);
                        n_out.is_new       = 1'b1;
                        n_out.unique_value = r_key;
                    end else begin
                        idx_ext        = '0;
                        n_out.overflow = 1'b1;
                    end
                    n_out.first_index  = idx_ext[INDEX_W-1:0];
                    n_out.unique_count = cnt_ext[COUNT_W-1:0];
                    if (r_last) begin
                        n_count = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_found     <= 1'b0;
            r_wide      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_pend   <= n_rd_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_wide <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_rd_addr <= n_rd_addr;
        r_hit_idx <= n_hit_idx;
        r_key     <= n_key;
        r_last    <= n_last;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= r_key;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[AW-1:0]];
        end
    end

endmodule
`default_nettype wire

// ===== design/sufi_checker.sv =====
`default_nettype none
module sufi_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire sufi_pkg::t_out_req o_out_data
);
    import sufi_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block ready right after accepting a request");

    a_new_not_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.is_new && o_out_data.overflow))
        else $error("result both new and overflow");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_new) |-> (o_out_data.unique_count != '0))
        else $error("new value with zero count");

    a_ovf_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |-> (o_out_data.first_index == '0))
        else $error("overflow with non-zero index");

endmodule

bind stream_unique_first_index_top sufi_checker u_sufi_checker (.*);
`default_nettype wire

// ===== tb/tb_stream_unique_first_index_top.sv =====
module tb_stream_unique_first_index_top;
    import sufi_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        logic     wide;
        t_in_req  req;
        logic     typed;
        t_out_req want;
    } t_probe;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    logic     cfg_wdata;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_data;
    logic     out_valid;
    logic     out_stall;
    t_out_req out_data;

    logic [VALUE_W-1:0] key_table [TABLE_DEPTH];
    int                 key_count = 0;
    logic               wide_mode = 1'b0;

    t_out_req answer_q [$];
    t_probe   probe_rows [$];
    int       errors = 0;
    int       requests_sent = 0;
    int       results_taken = 0;
    int       long_holds_asked = 0;
    logic     tx_idle = 1'b1;
    logic     rx_idle = 1'b1;

    stream_unique_first_index_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic t_out_req predict_first_index(input t_in_req r);
        t_out_req           res;
        logic [VALUE_W-1:0] key;
        logic               hit;
        int                 s;
        key = wide_mode ? r.value : {{32{r.value[31]}}, r.value[31:0]};
        res = '0;
        hit = 1'b0;
        for (s = 0; s < key_count && !hit; s++) begin
            if (key_table[s] == key) begin
                hit = 1'b1;
                res.first_index = INDEX_W'(s);
            end
        end
        if (!hit) begin
            if (key_count < TABLE_DEPTH) begin
                key_table[key_count] = key;
                res.first_index  = INDEX_W'(key_count);
                res.is_new       = 1'b1;
                res.unique_value = key;
                key_count++;
            end else begin
                res.overflow = 1'b1;
            end
        end
        res.unique_count = COUNT_W'(key_count);
        res.set_done     = r.last;
        if (r.last)
            key_count = 0;
        return res;
    endfunction

    task automatic flag_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
        errors++;
        $display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
    endtask

    always @(posedge clk) begin : result_check
        t_out_req want;
        if (rst_n && out_valid && !out_stall) begin
            results_taken = results_taken + 1;
            if (answer_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, expected none got %h",
                         $time, out_data);
            end else begin
                want = answer_q.pop_front();
                if (out_data.first_index !== want.first_index)
                    flag_field("first_index", want.first_index, out_data.first_index);
                if (out_data.is_new !== want.is_new)
                    flag_field("is_new", want.is_new, out_data.is_new);
                if (out_data.unique_value !== want.unique_value)
                    flag_field("unique_value", want.unique_value, out_data.unique_value);
                if (out_data.unique_count !== want.unique_count)
                    flag_field("unique_count", want.unique_count, out_data.unique_count);
                if (out_data.overflow !== want.overflow)
                    flag_field("overflow", want.overflow, out_data.overflow);
                if (out_data.set_done !== want.set_done)
                    flag_field("set_done", want.set_done, out_data.set_done);
            end
        end
    end

    initial begin : sink_stall
        int hold;
        int seen;
        int holds_done;
        hold       = 0;
        seen       = 0;
        holds_done = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (results_taken != seen) begin
                seen = results_taken;
                hold = rx_idle ? $urandom_range(0, 15) : 0;
            end
            if (long_holds_asked != holds_done) begin
                holds_done = long_holds_asked;
                hold       = 400;
            end
            out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    task automatic offer_value(input t_in_req r, input logic typed, input t_out_req typed_res);
        int       gap;
        t_out_req res;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_first_index(r);
        if (typed)
            res = typed_res;
        @(negedge clk);
        answer_q = {answer_q, res};
        requests_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_mode(input logic wide);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= wide;
        wide_mode  = wide;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_probe(input logic wide, input logic [63:0] v, input logic last,
                             input logic typed, input int idx, input logic is_new,
                             input logic [63:0] uval, input int cnt);
        t_probe p;
        p                   = '0;
        p.wide              = wide;
        p.req.value         = v;
        p.req.last          = last;
        p.typed             = typed;
        p.want.first_index  = INDEX_W'(idx);
        p.want.is_new       = is_new;
        p.want.unique_value = uval;
        p.want.unique_count = COUNT_W'(cnt);
        p.want.set_done     = last;
        probe_rows = {probe_rows, p};
    endtask

    task automatic run_small_set(input int size);
        logic [63:0] used [$];
        logic [63:0] v;
        t_in_req     r;
        int          i;
        int          pick;
        for (i = 0; i < size; i++) begin
            if (size >= 4 && i == size / 2 && $urandom_range(0, 5) == 0)
                set_mode(!wide_mode);
            pick = $urandom_range(0, 7);
            if (used.size() > 0 && pick < 3) begin
                v = used[$urandom_range(0, used.size() - 1)];
            end else if (used.size() > 0 && pick == 3) begin
                v        = used[$urandom_range(0, used.size() - 1)];
                v[63:32] = $urandom;
            end else if (pick == 4) begin
                case ($urandom_range(0, 5))
                    0:       v = 64'h0;
                    1:       v = 64'hFFFF_FFFF_FFFF_FFFF;
                    2:       v = 64'h8000_0000_0000_0000;
                    3:       v = 64'h7FFF_FFFF_FFFF_FFFF;
                    4:       v = {$urandom, 32'h8000_0000};
                    default: v = {$urandom, 32'h7FFF_FFFF};
                endcase
            end else begin
                v = {$urandom, $urandom};
            end
            used = {used, v};
            r.value = v;
            r.last  = (i == size - 1);
            offer_value(r, 1'b0, '0);
        end
    endtask

    task automatic fill_to_overflow();
        logic [63:0] raw_seen [$];
        t_in_req     r;
        int          k;
        if (wide_mode)
            set_mode(1'b0);
        tx_idle = $urandom_range(0, 1);
        rx_idle = $urandom_range(0, 1);
        while (key_count < TABLE_DEPTH) begin
            if (key_count >= TABLE_DEPTH / 2 && !wide_mode)
                set_mode(1'b1);
            if (raw_seen.size() > 0 && $urandom_range(0, 15) == 0)
                r.value = raw_seen[$urandom_range(0, raw_seen.size() - 1)];
            else
                r.value = {$urandom, $urandom};
            r.last = 1'b0;
            raw_seen = {raw_seen, r.value};
            offer_value(r, 1'b0, '0);
        end
        for (k = 0; k < 12; k++) begin
            case ($urandom_range(0, 2))
                0:       r.value = key_table[TABLE_DEPTH-1];
                1:       r.value = raw_seen[$urandom_range(0, raw_seen.size() - 1)];
                default: r.value = {$urandom, $urandom};
            endcase
            r.last = (k == 11);
            offer_value(r, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int i;
        int set_no;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // after reset, narrow mode
        add_probe(0, 64'h0,                   0, 1, 0, 1, 64'h0,                   1);
        add_probe(0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 2);
        add_probe(0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 1, 0, 64'h0,                   2);
        add_probe(0, 64'h8000_0000_0000_0000, 0, 1, 0, 0, 64'h0,                   2);
        add_probe(0, 64'h0000_0000_8000_0000, 0, 1, 2, 1, 64'hFFFF_FFFF_8000_0000, 3);
        add_probe(0, 64'h1234_5678_7FFF_FFFF, 1, 1, 3, 1, 64'h0000_0000_7FFF_FFFF, 4);
        add_probe(0, 64'h5,                   1, 1, 0, 1, 64'h5,                   1);
        // wide mode extremes
        add_probe(1, 64'h8000_0000_0000_0000, 0, 1, 0, 1, 64'h8000_0000_0000_0000, 1);
        add_probe(1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 2);
        add_probe(1, 64'h0,                   0, 1, 2, 1, 64'h0,                   3);
        add_probe(1, 64'h0000_0001_0000_0000, 0, 1, 3, 1, 64'h0000_0001_0000_0000, 4);
        add_probe(1, 64'h0,                   0, 1, 2, 0, 64'h0,                   4);
        // mode flips within the set
        add_probe(0, 64'h0000_0001_0000_0000, 0, 0, 0, 0, 64'h0, 0);
        add_probe(0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 64'h0, 0);
        add_probe(0, 64'hFFFF_FFFF_0000_0000, 0, 0, 0, 0, 64'h0, 0);
        add_probe(1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 64'h0, 0);
        add_probe(1, 64'hAAAA_5555_AAAA_5555, 0, 0, 0, 0, 64'h0, 0);
        add_probe(1, 64'hAAAA_5555_AAAA_5555, 1, 0, 0, 0, 64'h0, 0);

        set_mode(1'b0);
        for (i = 0; i < probe_rows.size(); i++) begin
            if (probe_rows[i].wide != wide_mode)
                set_mode(probe_rows[i].wide);
            offer_value(probe_rows[i].req, probe_rows[i].typed, probe_rows[i].want);
        end

        set_no = 0;
        while (requests_sent < 280) begin
            if ($urandom_range(0, 2) == 0)
                set_mode(!wide_mode);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (set_no == 2) begin
                long_holds_asked++;
                run_small_set(10);
            end else if ($urandom_range(0, 5) == 0) begin
                run_small_set($urandom_range(13, 60));
            end else begin
                run_small_set($urandom_range(1, 12));
            end
            set_no++;
        end

        fill_to_overflow();

        while (requests_sent < 1550) begin
            if ($urandom_range(0, 2) == 0)
                set_mode(!wide_mode);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                run_small_set($urandom_range(13, 60));
            else
                run_small_set($urandom_range(1, 12));
        end

        settle();
        repeat (TABLE_DEPTH + 16) @(negedge clk);
        if (errors == 0 && answer_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sufi_pkg.sv
design/stream_unique_first_index_top.sv
design/sufi_checker.sv
tb/tb_stream_unique_first_index_top.sv
